/* sv/sdbcs_pkg.sv */
// ---------------------------------------------------------------------------
// Scale-dependent bias chi-square package
// Shared types and constants of the chi-square accumulator.
// ---------------------------------------------------------------------------
package sdbcs_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_BIAS_AMPLITUDE        = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LINEAR_COEFFICIENT    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_QUADRATIC_COEFFICIENT = 2'd2;

   localparam logic signed [31:0] BIAS_AMPLITUDE_RESET = 32'sd65536;
   localparam logic signed [63:0] ONE_Q16              = 64'sd65536;
   localparam logic [47:0]        SUM_MAX              = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic               last;
      logic               inv;
      logic signed [31:0] bias;
      logic signed [31:0] sigma;
   } side_type;

   typedef struct packed {
      logic last;
      logic inv;
   } tag_type;

endpackage

/* sv/scale_dependent_bias_chi_square.sv */
// ---------------------------------------------------------------------------
// Scale-dependent bias chi-square accumulator
// Fits the bias model b0*sqrt((1+Q*k^2)/(1+A*k)) against measured points and
// accumulates a saturating weighted chi-square sum.
// ---------------------------------------------------------------------------
// The block takes one word per clock cycle while it is not stalled. Five
// front stages form k^2, the numerator and the denominator, a 31-stage
// divider forms the ratio, a 24-stage root extractor takes its square root,
// four stages form the deviation and its weight, a 48-stage divider forms
// the term, and the final stage adds it to the sum. A result is given only
// for a point marked last; the pipeline stalls only when such a point meets
// a result not yet taken.
module scale_dependent_bias_chi_square
   import sdbcs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // wavenumber [31:0], measured_bias [63:32], bias_error [95:64]
   input  logic [95:0]            req_tdata,
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // chi_square [47:0]
   output logic [47:0]            rsp_tdata,
   // status [0]
   output logic                   rsp_tuser,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic               adv;
   logic signed [31:0] bias_amp_ff;
   logic signed [31:0] lin_ff;
   logic signed [31:0] quad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_amp_ff <= BIAS_AMPLITUDE_RESET;
         lin_ff      <= '0;
         quad_ff     <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_BIAS_AMPLITUDE: begin
               bias_amp_ff <= csr_wdata;
            end
            REG_LINEAR_COEFFICIENT: begin
               lin_ff <= csr_wdata;
            end
            REG_QUADRATIC_COEFFICIENT: begin
               quad_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Front stages.
   logic signed [31:0] k;
   side_type           in_side;
   logic               p1_v_ff, p2_v_ff, p3_v_ff, p4_v_ff, p5_v_ff;
   logic signed [63:0] p1_kk_ff, p1_ak_ff;
   side_type           p1_side_ff, p2_side_ff, p3_side_ff, p4_side_ff, p5_side_ff;
   side_type           p2_side_in, p4_side_in, p5_side_in;
   logic signed [63:0] kk_sh, den_full;
   logic               kk_ok, den_ok;
   logic signed [31:0] p2_kk_ff;
   logic [30:0]        p2_den_ff, p3_den_ff, p4_den_ff, p5_den_ff;
   logic signed [63:0] p3_qkk_ff;
   logic signed [63:0] num_full;
   logic               num_ok;
   logic [30:0]        p4_num_ff, p5_num_ff;
   logic               ratio_ovf;

   assign k             = req_tdata[31:0];
   assign in_side.last  = req_tlast;
   assign in_side.inv   = 1'b0;
   assign in_side.bias  = req_tdata[63:32];
   assign in_side.sigma = req_tdata[95:64];

   always_comb begin
      kk_sh     = p1_kk_ff >>> 16;
      kk_ok     = (kk_sh[63:31] == '0);
      den_full  = (p1_ak_ff >>> 16) + ONE_Q16;
      den_ok    = ~den_full[63] && (den_full[62:31] == '0) && (den_full[30:0] != '0);
      num_full  = (p3_qkk_ff >>> 16) + ONE_Q16;
      num_ok    = ~num_full[63] && (num_full[62:31] == '0);
      ratio_ovf = {15'b0, p4_num_ff} >= {p4_den_ff, 15'b0};
      p2_side_in     = p1_side_ff;
      p2_side_in.inv = p1_side_ff.inv | ~kk_ok | ~den_ok;
      p4_side_in     = p3_side_ff;
      p4_side_in.inv = p3_side_ff.inv | ~num_ok;
      p5_side_in     = p4_side_ff;
      p5_side_in.inv = p4_side_ff.inv | ratio_ovf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         p4_v_ff <= 1'b0;
         p5_v_ff <= 1'b0;
      end else if (adv) begin
         p1_v_ff <= req_tvalid;
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
         p4_v_ff <= p3_v_ff;
         p5_v_ff <= p4_v_ff;
      end
      if (adv) begin
         p1_kk_ff   <= k * k;
         p1_ak_ff   <= lin_ff * k;
         p1_side_ff <= in_side;

         p2_kk_ff   <= kk_sh[31:0];
         p2_den_ff  <= den_full[30:0];
         p2_side_ff <= p2_side_in;

         p3_qkk_ff  <= quad_ff * p2_kk_ff;
         p3_den_ff  <= p2_den_ff;
         p3_side_ff <= p2_side_ff;

         p4_num_ff  <= num_full[30:0];
         p4_den_ff  <= p3_den_ff;
         p4_side_ff <= p4_side_in;

         p5_num_ff  <= p4_num_ff;
         p5_den_ff  <= p4_den_ff;
         p5_side_ff <= p5_side_in;
      end
   end

   // Ratio and its square root.
   logic        r_v;
   logic [30:0] r_quo;
   side_type    r_side;
   logic        s_v;
   logic [23:0] s_root;
   side_type    s_side;

   sdbcs_div #(
      .NW (47),
      .DW (31),
      .QB (31),
      .SW ($bits(side_type))
   ) u_ratio_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (p5_v_ff),
      .in_num    ({p5_num_ff, 16'b0}),
      .in_den    (p5_den_ff),
      .in_side   (p5_side_ff),
      .out_valid (r_v),
      .out_quo   (r_quo),
      .out_side  (r_side)
   );

   sdbcs_sqrt #(
      .RW (24),
      .SW ($bits(side_type))
   ) u_root (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (r_v),
      .in_v      ({1'b0, r_quo, 16'b0}),
      .in_side   (r_side),
      .out_valid (s_v),
      .out_root  (s_root),
      .out_side  (s_side)
   );

   // Deviation and weight stages.
   logic               p6_v_ff, p7_v_ff, p8_v_ff, p9_v_ff;
   logic signed [56:0] p6_m_ff;
   side_type           p6_side_ff, p7_side_ff, p8_side_ff;
   side_type           p7_side_in;
   logic signed [56:0] m_sh;
   logic signed [32:0] d_full;
   logic               m_ok, d_ok, sig_zero;
   logic signed [31:0] p7_d_ff;
   logic signed [63:0] d2_full, s2_full;
   logic [62:0]        p8_d2_ff, p8_s2_ff, p9_d2_ff, p9_s2_ff;
   logic               term_ovf;
   tag_type            p9_tag_ff;

   always_comb begin
      m_sh     = p6_m_ff >>> 16;
      m_ok     = (m_sh[56:31] == '0) || (m_sh[56:31] == '1);
      d_full   = {p6_side_ff.bias[31], p6_side_ff.bias} - {m_sh[31], m_sh[31:0]};
      d_ok     = (d_full[32] == d_full[31]);
      sig_zero = (p6_side_ff.sigma == '0);
      p7_side_in     = p6_side_ff;
      p7_side_in.inv = p6_side_ff.inv | ~m_ok | ~d_ok | sig_zero;
      d2_full  = p7_d_ff * p7_d_ff;
      s2_full  = p7_side_ff.sigma * p7_side_ff.sigma;
      term_ovf = {32'b0, p8_d2_ff[62:32]} >= p8_s2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p6_v_ff <= 1'b0;
         p7_v_ff <= 1'b0;
         p8_v_ff <= 1'b0;
         p9_v_ff <= 1'b0;
      end else if (adv) begin
         p6_v_ff <= s_v;
         p7_v_ff <= p6_v_ff;
         p8_v_ff <= p7_v_ff;
         p9_v_ff <= p8_v_ff;
      end
      if (adv) begin
         p6_m_ff    <= bias_amp_ff * $signed({1'b0, s_root});
         p6_side_ff <= s_side;

         p7_d_ff    <= d_full[31:0];
         p7_side_ff <= p7_side_in;

         p8_d2_ff   <= d2_full[62:0];
         p8_s2_ff   <= s2_full[62:0];
         p8_side_ff <= p7_side_ff;

         p9_d2_ff       <= p8_d2_ff;
         p9_s2_ff       <= p8_s2_ff;
         p9_tag_ff.last <= p8_side_ff.last;
         p9_tag_ff.inv  <= p8_side_ff.inv | term_ovf;
      end
   end

   // Term division.
   logic        fin_v;
   logic [47:0] fin_term;
   tag_type     fin_tag;

   sdbcs_div #(
      .NW (79),
      .DW (63),
      .QB (48),
      .SW ($bits(tag_type))
   ) u_term_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (p9_v_ff),
      .in_num    ({p9_d2_ff, 16'b0}),
      .in_den    (p9_s2_ff),
      .in_side   (p9_tag_ff),
      .out_valid (fin_v),
      .out_quo   (fin_term),
      .out_side  (fin_tag)
   );

   // Accumulator and result register.
   logic [47:0] sum_ff, sum_in, sum_upd;
   logic        inv_seen_ff, inv_seen_in, inv_upd;
   logic [48:0] sum_add;
   logic        acc_go;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_sum_ff, rsp_sum_in;
   logic        rsp_status_ff, rsp_status_in;

   assign adv        = ~(rsp_valid_ff & ~rsp_tready & fin_v & fin_tag.last);
   assign req_tready = adv;
   assign acc_go     = fin_v & adv;

   always_comb begin
      sum_add       = {1'b0, sum_ff} + {1'b0, fin_term};
      sum_upd       = fin_tag.inv ? sum_ff : (sum_add[48] ? SUM_MAX : sum_add[47:0]);
      inv_upd       = inv_seen_ff | fin_tag.inv | sum_add[48];
      sum_in        = sum_ff;
      inv_seen_in   = inv_seen_ff;
      rsp_sum_in    = rsp_sum_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      if (acc_go) begin
         if (fin_tag.last) begin
            sum_in        = '0;
            inv_seen_in   = 1'b0;
            rsp_sum_in    = sum_upd;
            rsp_status_in = inv_upd;
            rsp_valid_in  = 1'b1;
         end else begin
            sum_in      = sum_upd;
            inv_seen_in = inv_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         inv_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         inv_seen_ff  <= inv_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_sum_ff    <= rsp_sum_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sum_ff;
   assign rsp_tuser  = rsp_status_ff;

   a_last_gives_word: assert property (@(posedge clock) disable iff (reset)
      acc_go && fin_tag.last |=> rsp_valid_ff)
      else $error("A last point did not produce a result word.");

   a_last_clears_sum: assert property (@(posedge clock) disable iff (reset)
      acc_go && fin_tag.last |=> sum_ff == '0 && !inv_seen_ff)
      else $error("The sum was not cleared after a last point.");

   a_invalid_sticks: assert property (@(posedge clock) disable iff (reset)
      acc_go && fin_tag.inv && !fin_tag.last |=> inv_seen_ff)
      else $error("An invalid point did not set the status flag.");

endmodule

/* sv/sdbcs_div.sv */
// ---------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage; the caller guarantees that the
// quotient fits in QB bits.
// ---------------------------------------------------------------------------
module sdbcs_div #(
   parameter int NW = 47,
   parameter int DW = 31,
   parameter int QB = 31,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QB-1:0] out_quo,
   output logic [SW-1:0] out_side
);

   logic [DW-1:0] rem_w  [0:QB];
   logic [QB-1:0] lq_w   [0:QB];
   logic [DW-1:0] den_w  [0:QB];
   logic [SW-1:0] side_w [0:QB];
   logic          v_w    [0:QB];

   assign rem_w[0]  = DW'(in_num >> QB);
   assign lq_w[0]   = in_num[QB-1:0];
   assign den_w[0]  = in_den;
   assign side_w[0] = in_side;
   assign v_w[0]    = in_valid;

   for (genvar i = 0; i < QB; i++) begin : g_stage
      logic [DW:0]   t;
      logic [DW:0]   diff;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [QB-1:0] lq_in;
      logic [DW-1:0] rem_ff;
      logic [QB-1:0] lq_ff;
      logic [DW-1:0] den_ff;
      logic [SW-1:0] side_ff;
      logic          v_ff;

      always_comb begin
         t      = {rem_w[i], lq_w[i][QB-1]};
         diff   = t - {1'b0, den_w[i]};
         ge     = ~diff[DW];
         rem_in = ge ? diff[DW-1:0] : t[DW-1:0];
         lq_in  = {lq_w[i][QB-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (adv) begin
            v_ff <= v_w[i];
         end
         if (adv) begin
            rem_ff  <= rem_in;
            lq_ff   <= lq_in;
            den_ff  <= den_w[i];
            side_ff <= side_w[i];
         end
      end

      assign rem_w[i+1]  = rem_ff;
      assign lq_w[i+1]   = lq_ff;
      assign den_w[i+1]  = den_ff;
      assign side_w[i+1] = side_ff;
      assign v_w[i+1]    = v_ff;
   end

   assign out_valid = v_w[QB];
   assign out_quo   = lq_w[QB];
   assign out_side  = side_w[QB];

endmodule

/* sv/sdbcs_sqrt.sv */
// ---------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit floor square root, one result bit per register stage.
// ---------------------------------------------------------------------------
module sdbcs_sqrt #(
   parameter int RW = 24,
   parameter int SW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  logic            in_valid,
   input  logic [2*RW-1:0] in_v,
   input  logic [SW-1:0]   in_side,
   output logic            out_valid,
   output logic [RW-1:0]   out_root,
   output logic [SW-1:0]   out_side
);

   logic [2*RW-1:0] vsh_w  [0:RW];
   logic [RW+1:0]   rem_w  [0:RW];
   logic [RW-1:0]   root_w [0:RW];
   logic [SW-1:0]   side_w [0:RW];
   logic            v_w    [0:RW];

   assign vsh_w[0]  = in_v;
   assign rem_w[0]  = '0;
   assign root_w[0] = '0;
   assign side_w[0] = in_side;
   assign v_w[0]    = in_valid;

   for (genvar i = 0; i < RW; i++) begin : g_stage
      logic [RW+3:0]   pre;
      logic [RW+3:0]   diff;
      logic            ge;
      logic [RW+1:0]   rem_in;
      logic [RW-1:0]   root_in;
      logic [2*RW-1:0] vsh_in;
      logic [2*RW-1:0] vsh_ff;
      logic [RW+1:0]   rem_ff;
      logic [RW-1:0]   root_ff;
      logic [SW-1:0]   side_ff;
      logic            v_ff;

      always_comb begin
         pre     = {rem_w[i], vsh_w[i][2*RW-1 -: 2]};
         diff    = pre - {2'b00, root_w[i], 2'b01};
         ge      = ~diff[RW+3];
         rem_in  = ge ? diff[RW+1:0] : pre[RW+1:0];
         root_in = {root_w[i][RW-2:0], ge};
         vsh_in  = {vsh_w[i][2*RW-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (adv) begin
            v_ff <= v_w[i];
         end
         if (adv) begin
            vsh_ff  <= vsh_in;
            rem_ff  <= rem_in;
            root_ff <= root_in;
            side_ff <= side_w[i];
         end
      end

      assign vsh_w[i+1]  = vsh_ff;
      assign rem_w[i+1]  = rem_ff;
      assign root_w[i+1] = root_ff;
      assign side_w[i+1] = side_ff;
      assign v_w[i+1]    = v_ff;
   end

   assign out_valid = v_w[RW];
   assign out_root  = root_w[RW];
   assign out_side  = side_w[RW];

endmodule
